### src/wildcard_star_matcher_macros.svh
// Assertion macros shared by the wildcard star matcher RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef WILDCARD_STAR_MATCHER_MACROS_SVH
`define WILDCARD_STAR_MATCHER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define WSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define WSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### src/wsm_pkg.sv
// Shared constants and types of the wildcard star matcher.
// Used by wsm_row_next and wildcard_star_matcher; depends on nothing.
package wsm_pkg;

  // Significant bits of a symbol code; wider settings keep the whole byte.
  localparam int SYMBOL_BITS     = 8;
  // Width of a symbol field and of one pattern byte.
  localparam int SYM_W           = 8;
  localparam int MAX_PATTERN_DEF = 32;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int BYTES_PER_WORD  = CFG_DATA_W / SYM_W;

  localparam logic [SYM_W-1:0] SYM_MASK =
    (SYMBOL_BITS >= SYM_W) ? {SYM_W{1'b1}} : SYM_W'((1 << SYMBOL_BITS) - 1);
  localparam logic [SYM_W-1:0] STAR_CODE = 8'h2A & SYM_MASK;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgPatWord0  = CFG_IDX_W'(0),
    CfgPatWord1  = CFG_IDX_W'(1),
    CfgPatWord2  = CFG_IDX_W'(2),
    CfgPatWord3  = CFG_IDX_W'(3),
    CfgPatLength = CFG_IDX_W'(4)
  } cfg_idx_e;

  // One input word as held in the input register.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             first_sym;
    logic             last_sym;
    logic             empty_txt;
  } wsm_item_t;

endpackage

### src/wsm_row_next.sv
// Next-row logic of the wildcard star matcher: one text symbol against the pattern.
// Depends on wsm_pkg. Purely combinational; two parallel-prefix networks.
module wsm_row_next import wsm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  localparam int LenBits    = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN-1:0][SYM_W-1:0] pattern_i,
  input  logic [LenBits-1:0]                len_i,
  input  logic [MAX_PATTERN:0]              row_i,
  input  wsm_item_t                         item_i,
  output logic [MAX_PATTERN:0]              row_o,
  output logic                              matched_o
);

  localparam int Levels = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN:0] star;
  logic [MAX_PATTERN:0] hit;
  logic [MAX_PATTERN:0] init_row;
  logic [MAX_PATTERN:0] base_row;
  logic [Levels:0][MAX_PATTERN:0] and_lvl;
  logic [Levels:0][MAX_PATTERN:0] gen_lvl;
  logic [Levels:0][MAX_PATTERN:0] prp_lvl;

  // Position j of the row stands after pattern symbol j-1; positions past
  // the pattern length never take part.
  always_comb begin
    star = '0;
    hit  = '0;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      if (len_i >= LenBits'(j)) begin
        star[j] = ((pattern_i[j-1] & SYM_MASK) == STAR_CODE);
        hit[j]  = !star[j] && (((pattern_i[j-1] ^ item_i.symbol) & SYM_MASK) == '0);
      end
    end
  end

  // Initial row: bit j is set when every pattern symbol before it is a star.
  always_comb begin
    and_lvl[0] = {star[MAX_PATTERN:1], 1'b1};
    for (int l = 0; l < Levels; l++) begin
      and_lvl[l+1] = and_lvl[l];
      for (int j = 0; j <= MAX_PATTERN; j++) begin
        if (j >= (1 << l)) begin
          and_lvl[l+1][j] = and_lvl[l][j] & and_lvl[l][j - (1 << l)];
        end
      end
    end
    init_row = and_lvl[Levels];
  end

  assign base_row = item_i.first_sym ? init_row : row_i;

  // New row: nr[j] = g[j] | (star[j] & nr[j-1]), solved as a carry prefix.
  always_comb begin
    gen_lvl[0] = '0;
    prp_lvl[0] = star;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      gen_lvl[0][j] = star[j] ? base_row[j] : (hit[j] & base_row[j-1]);
    end
    for (int l = 0; l < Levels; l++) begin
      gen_lvl[l+1] = gen_lvl[l];
      prp_lvl[l+1] = prp_lvl[l];
      for (int j = 0; j <= MAX_PATTERN; j++) begin
        if (j >= (1 << l)) begin
          gen_lvl[l+1][j] = gen_lvl[l][j] | (prp_lvl[l][j] & gen_lvl[l][j - (1 << l)]);
          prp_lvl[l+1][j] = prp_lvl[l][j] & prp_lvl[l][j - (1 << l)];
        end
      end
    end
  end

  assign row_o     = item_i.empty_txt ? init_row : gen_lvl[Levels];
  assign matched_o = row_o[len_i];

endmodule

### src/wildcard_star_matcher.sv
// Top level of the wildcard star matcher: pattern registers, pipeline and handshakes.
// Depends on wsm_pkg, wsm_row_next and wildcard_star_matcher_macros.svh.
//
// Usage: the pattern is written through the configuration port (indices 0 to 3
// carry eight pattern symbols each, lowest byte first; index 4 the length) while
// the block is idle. Text symbols then arrive as words on the input channel,
// one per cycle at most. first_symbol_i restarts the match row from the
// pattern's initial row; empty_text_i stands for a text of no symbols. A word
// with last_symbol_i set yields one result word on the output channel,
// matched_o, which tells whether the whole text fits the whole pattern.
// A word is held in the input register, its result in the output register.
// Throughput is one text symbol per cycle unless a text end waits on a
// stalled receiver; the match row update is a single register-to-register
// pass through two prefix networks of ceil(log2(MAX_PATTERN+1)) levels each.
// Reset clears the pattern, the length, the match row and both valid flags;
// a text that does not open with a first symbol after reset never matches.
// While the receiver stalls, the result waits in the output register, and one
// more word is still taken into the input register; a word that ends a text
// then waits there, while words that do not end a text keep flowing.
module wildcard_star_matcher import wsm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Text symbol channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SYM_W-1:0]      text_symbol_i,
  input  logic                  first_symbol_i,
  input  logic                  last_symbol_i,
  input  logic                  empty_text_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  matched_o
);

`include "wildcard_star_matcher_macros.svh"

  localparam int LenBits = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][SYM_W-1:0] pattern_q;
  logic [LenBits-1:0]                len_q;
  logic [LenBits-1:0]                len_d;

  logic                 s1_valid_q;
  wsm_item_t            s1_item_q;
  logic                 s1_go;
  logic [MAX_PATTERN:0] row_q;
  logic [MAX_PATTERN:0] row_d;
  logic                 match_d;
  logic                 out_valid_q;
  logic                 matched_q;

  // Pattern bytes: byte j lives in lane j mod 8 of configuration word j / 8.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat_byte
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pattern_q[j] <= '0;
      end else if (cfg_we_i && (cfg_index_i == CFG_IDX_W'(j / BYTES_PER_WORD))) begin
        pattern_q[j] <= cfg_data_i[(j % BYTES_PER_WORD)*SYM_W +: SYM_W];
      end
    end
  end

  // The length is clamped to what the row can hold as it is written.
  always_comb begin
    if (cfg_data_i[5:0] > 6'(MAX_PATTERN)) begin
      len_d = LenBits'(MAX_PATTERN);
    end else begin
      len_d = cfg_data_i[LenBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPatLength: len_q <= len_d;
        default:      len_q <= len_q;
      endcase
    end
  end

  // Input stage. A word that ends a text needs room in the output register;
  // any other word only updates the row and always moves on.
  assign s1_go      = s1_valid_q && (!s1_item_q.last_sym || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= '{symbol:    text_symbol_i,
                     first_sym: first_symbol_i,
                     last_sym:  last_symbol_i,
                     empty_txt: empty_text_i};
    end
  end

  wsm_row_next #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_row_next (
    .pattern_i(pattern_q),
    .len_i    (len_q),
    .row_i    (row_q),
    .item_i   (s1_item_q),
    .row_o    (row_d),
    .matched_o(match_d)
  );

  // The match row carries over from one word to the next, also across texts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (s1_go) begin
      row_q <= row_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_item_q.last_sym) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_item_q.last_sym) begin
      matched_q <= match_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // A word that does not end a text is never held back by the output side.
  `WSM_ASSERT_IMP(a_nolast_flows, s1_valid_q && !s1_item_q.last_sym, s1_go)
  // A pending text end facing a stalled output blocks the input.
  `WSM_ASSERT_IMP(a_last_blocks,
    s1_valid_q && s1_item_q.last_sym && out_valid_q && !out_ready_i, !in_ready_o)
  // The row only moves when a word is consumed.
  `WSM_ASSERT_NXT(a_row_hold, !s1_go, row_q == $past(row_q))
  // Row position zero is set exactly after an empty text.
  `WSM_ASSERT_NXT(a_row_origin, s1_go, row_q[0] == $past(s1_item_q.empty_txt))
  // A new result only ever comes from a consumed text end.
  `WSM_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(s1_go && s1_item_q.last_sym))

endmodule
